>>> design/thst_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the typed handle slot table.
package thst_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int SLOT_NUM_W = 6;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] handle_value;
    logic [3:0]  handle_tag;
    logic [15:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic [63:0]           found_value;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } thst_ctl_t;

endpackage

>>> design/typed_handle_slot_table_core.sv
`timescale 1ns / 1ps
// Typed handle slot table: insert into lowest free slot, lookup and remove by index.
//
// A command beat is taken when start is high and busy is low. The next cycle
// reads the entry RAM (registered read) and does the read-modify-write, with
// the lowest free slot picked by a priority encoder over the reserved flags;
// busy is high for that one cycle. The result is registered and shows on
// out_item with out_strobe, high for exactly one cycle, in the cycle after it,
// and must be taken then, as the receiver cannot hold it off. A new beat may
// be taken in that same cycle. No clearing pass is needed after reset.
module typed_handle_slot_table_core import thst_pkg::*; #(
  parameter int SLOTS     = 64,
  parameter int TYPE_BITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output out_item_t out_item,
  output logic      out_strobe
);

  thst_ctl_t ctl;

  thst_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .ctl  (ctl)
  );

  thst_dp #(
    .SLOTS    (SLOTS),
    .TYPE_BITS(TYPE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_strobe(out_strobe)
  );

endmodule

>>> design/thst_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module thst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/thst_ctrl.sv
`timescale 1ns / 1ps
// Controller: accept a beat, then execute it in the S_EXEC state.
module thst_ctrl import thst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output thst_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign ctl.load = start && (state_r == S_IDLE);
  assign ctl.exec = (state_r == S_EXEC);

endmodule

>>> design/thst_dp.sv
`timescale 1ns / 1ps
// Datapath: reserved flags, slot count, free-slot encoder, entry RAM, result register.
module thst_dp import thst_pkg::*; #(
  parameter int SLOTS     = 64,
  parameter int TYPE_BITS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  thst_ctl_t ctl,
  input  in_item_t  in_item,
  output out_item_t out_item,
  output logic      out_strobe
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = TYPE_BITS + 64;

  logic [1:0]           cmd_r;
  logic [63:0]          value_r;
  logic [TYPE_BITS-1:0] typ_r;
  logic [15:0]          idx_r;

  logic [SLOTS-1:0] reserved_r, reserved_nxt;
  logic [CW-1:0]    created_r, created_nxt;

  logic [EW-1:0]    rdata;
  logic             we;
  logic [AW-1:0]    waddr;

  logic [SLOTS-1:0] free;
  logic             any_free;
  logic [AW-1:0]    first_free;
  logic             in_range;
  logic             type_hit;
  logic [AW-1:0]    ins_slot;

  out_item_t        res;
  out_item_t        out_r;
  logic             strobe_r;

  thst_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({typ_r, value_r}),
    .re   (ctl.load),
    .raddr(in_item.slot_index[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_item.command;
      value_r <= in_item.handle_value;
      typ_r   <= TYPE_BITS'({{TYPE_BITS{1'b0}}, in_item.handle_tag});
      idx_r   <= in_item.slot_index;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free[i] = !reserved_r[i] && (CW'(i) < created_r);
    end
    any_free   = |free;
    first_free = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free[i]) begin
        first_free = AW'(i);
      end
    end
  end

  assign in_range = {1'b0, idx_r} < 17'(created_r);
  assign type_hit = (rdata[EW-1:64] == typ_r);

  always_comb begin
    res          = '0;
    res.status   = ST_MISS;
    reserved_nxt = reserved_r;
    created_nxt  = created_r;
    we           = 1'b0;
    ins_slot     = any_free ? first_free : created_r[AW-1:0];
    waddr        = ins_slot;
    if (ctl.exec) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (!any_free && (created_r == CW'(SLOTS))) begin
            res.status = ST_FULL;
          end else begin
            res.status           = ST_OK;
            res.slot_number      = SLOT_NUM_W'(ins_slot);
            reserved_nxt[ins_slot] = 1'b1;
            we                   = 1'b1;
            if (!any_free) begin
              created_nxt = created_r + CW'(1);
            end
          end
        end
        CMD_LOOKUP: begin
          if (in_range && reserved_r[idx_r[AW-1:0]] && type_hit) begin
            res.status      = ST_OK;
            res.found_value = rdata[63:0];
          end
        end
        CMD_REMOVE: begin
          if (in_range && type_hit) begin
            res.status                   = ST_OK;
            reserved_nxt[idx_r[AW-1:0]] = 1'b0;
          end
        end
        default: begin
          res.status = ST_MISS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= '0;
      created_r  <= '0;
      strobe_r   <= 1'b0;
    end else begin
      reserved_r <= reserved_nxt;
      created_r  <= created_nxt;
      strobe_r   <= ctl.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_r <= res;
    end
  end

  assign out_item   = out_r;
  assign out_strobe = strobe_r;

endmodule
